// ----- rtl/ultrasonic_echo_ranger_top_defines.svh -----
// Assertion macros shared by the echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define UER_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/uer_pkg.sv -----
// Types and constants of the ultrasonic echo ranger.
package uer_pkg;

	// Samples averaged per sensor; the average is a shift by SAMPLE_SHIFT
	localparam int SAMPLE_COUNT = 8;
	localparam int SAMPLE_SHIFT = 3;
	localparam int SAMPLE_IDX_W = 3;

	// Sensor of the front position, sensors below it are side sensors
	localparam logic [1:0] FRONT_SENSOR = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_SIDE_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_STOP_LIMIT     = 2'd1;
	localparam logic [1:0] REG_DANGER_LIMIT   = 2'd2;
	localparam logic [1:0] REG_FRONT_LIMIT    = 2'd3;

	// Configuration reset values in ticks
	localparam logic [15:0] SIDE_THRESHOLD_RST = 16'd583;
	localparam logic [15:0] STOP_LIMIT_RST     = 16'd146;
	localparam logic [15:0] DANGER_LIMIT_RST   = 16'd292;
	localparam logic [15:0] FRONT_LIMIT_RST    = 16'd583;

	// Alert codes
	localparam logic [2:0] ALERT_NONE   = 3'd0;
	localparam logic [2:0] ALERT_SIDE   = 3'd1;
	localparam logic [2:0] ALERT_FRONT  = 3'd2;
	localparam logic [2:0] ALERT_DANGER = 3'd3;
	localparam logic [2:0] ALERT_STOP   = 3'd4;

	// Beep counts
	localparam logic [1:0] BEEP_NONE   = 2'd0;
	localparam logic [1:0] BEEP_ONE    = 2'd1;
	localparam logic [1:0] BEEP_DANGER = 2'd2;
	localparam logic [1:0] BEEP_STOP   = 2'd3;

	// Voice messages; side alerts use the sensor number
	localparam logic [2:0] VOICE_NONE   = 3'd0;
	localparam logic [2:0] VOICE_FRONT  = 3'd2;
	localparam logic [2:0] VOICE_STOP   = 3'd3;
	localparam logic [2:0] VOICE_DANGER = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TRIG  = 2'd1,
		PH_WAIT  = 2'd2,
		PH_COUNT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] side_threshold;
		logic [15:0] stop_limit;
		logic [15:0] danger_limit;
		logic [15:0] front_limit;
	} cfg_regs_t;

	typedef struct packed {
		logic [2:0] alert_code;
		logic [1:0] beep_count;
		logic [2:0] voice_index;
	} verdict_t;

	typedef struct packed {
		logic       start_request;
		logic [2:0] echo_levels;
	} req_t;

	typedef struct packed {
		logic [2:0]  trigger_lines;
		logic        busy_res;
		logic        result_valid;
		logic [1:0]  sensor_number;
		logic [15:0] average_ticks;
		logic [2:0]  alert_code;
		logic [1:0]  beep_count;
		logic [2:0]  voice_index;
	} res_t;

endpackage

// ----- rtl/ultrasonic_echo_ranger_top.sv -----
// Top level of the ultrasonic echo ranger: tick sequencer and result register.
// The result of a tick request is registered when it is accepted and is valid in the next cycle.
// Throughput: one tick request per cycle; the result register takes a new
// result whenever it is empty or being drained in the same cycle.
// Reset: arst_n clears the sequencer to idle and loads the default thresholds.
`include "ultrasonic_echo_ranger_top_defines.svh"

module ultrasonic_echo_ranger_top
	import uer_pkg::*;
#(
	parameter int SENSOR_COUNT = 3,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req_data,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int SUM_W = COUNT_WIDTH + SAMPLE_SHIFT;
	localparam logic [SUM_W-1:0] AVG_MAX = SUM_W'(17'h0FFFF);
	localparam logic [1:0] LAST_SENSOR = 2'(SENSOR_COUNT - 1);
	localparam logic [SAMPLE_IDX_W-1:0] LAST_SAMPLE = SAMPLE_IDX_W'(SAMPLE_COUNT - 1);

	cfg_regs_t                 cfg_q;
	phase_t                    phase_q, phase_d;
	logic [1:0]                sensor_q, sensor_d;
	logic [SAMPLE_IDX_W-1:0]   sample_q, sample_d;
	logic [COUNT_WIDTH-1:0]    pulse_q, pulse_d;
	logic [SUM_W-1:0]          sum_q, sum_d;
	logic                      pending_q, pending_d;

	logic                      accept;
	logic [3:0]                echo_ext;
	logic                      my_echo;
	logic [SUM_W-1:0]          sum_done;
	logic [SUM_W-1:0]          avg_full;
	logic [15:0]               avg_sat;
	verdict_t                  verdict;
	res_t                      res_d;

	// Accept a request whenever the result register can take its result
	assign accept    = req_valid && req_ready;
	assign req_ready = !res_valid || res_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_threshold <= SIDE_THRESHOLD_RST;
			cfg_q.stop_limit     <= STOP_LIMIT_RST;
			cfg_q.danger_limit   <= DANGER_LIMIT_RST;
			cfg_q.front_limit    <= FRONT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_THRESHOLD: cfg_q.side_threshold <= cfg_wdata;
				REG_STOP_LIMIT:     cfg_q.stop_limit     <= cfg_wdata;
				REG_DANGER_LIMIT:   cfg_q.danger_limit   <= cfg_wdata;
				REG_FRONT_LIMIT:    cfg_q.front_limit    <= cfg_wdata;
			endcase
		end
	end

	// Echo of the sensor being ranged
	assign echo_ext = {1'b0, req_data.echo_levels};
	assign my_echo  = echo_ext[sensor_q];

	// Average of the finished sum, saturated to the result width
	assign sum_done = sum_q + SUM_W'(pulse_q);
	assign avg_full = sum_done >> SAMPLE_SHIFT;
	assign avg_sat  = (avg_full > AVG_MAX) ? 16'hFFFF : 16'(avg_full);

	uer_classify u_classify (
		.sensor  (sensor_q),
		.average (avg_sat),
		.cfg     (cfg_q),
		.verdict (verdict)
	);

	// Next state and result of one tick
	always_comb begin
		phase_d   = phase_q;
		sensor_d  = sensor_q;
		sample_d  = sample_q;
		pulse_d   = pulse_q;
		sum_d     = sum_q;
		pending_d = pending_q;
		res_d     = '0;
		res_d.busy_res = (phase_q != PH_IDLE);

		if (phase_q != PH_IDLE && req_data.start_request) begin
			pending_d = 1'b1;
		end

		unique case (phase_q)
			PH_IDLE: begin
				if (req_data.start_request || pending_q) begin
					pending_d      = 1'b0;
					sensor_d       = '0;
					sample_d       = '0;
					sum_d          = '0;
					pulse_d        = '0;
					phase_d        = PH_TRIG;
					res_d.busy_res = 1'b1;
				end
			end
			PH_TRIG: begin
				res_d.trigger_lines = 3'(4'b0001 << sensor_q);
				pulse_d = '0;
				phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (my_echo) begin
					pulse_d = COUNT_WIDTH'(1);
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (my_echo) begin
					// Saturate the pulse width
					if (pulse_q != '1) begin
						pulse_d = pulse_q + COUNT_WIDTH'(1);
					end
				end else if (sample_q == LAST_SAMPLE) begin
					res_d.result_valid  = 1'b1;
					res_d.sensor_number = sensor_q;
					res_d.average_ticks = avg_sat;
					res_d.alert_code    = verdict.alert_code;
					res_d.beep_count    = verdict.beep_count;
					res_d.voice_index   = verdict.voice_index;
					sample_d = '0;
					sum_d    = '0;
					if (sensor_q == LAST_SENSOR) begin
						sensor_d = '0;
						phase_d  = PH_IDLE;
					end else begin
						sensor_d = sensor_q + 2'd1;
						phase_d  = PH_TRIG;
					end
				end else begin
					sum_d    = sum_done;
					sample_d = sample_q + SAMPLE_IDX_W'(1);
					phase_d  = PH_TRIG;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Sequencer state advances on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sensor_q  <= '0;
			sample_q  <= '0;
			pulse_q   <= '0;
			sum_q     <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			sensor_q  <= sensor_d;
			sample_q  <= sample_d;
			pulse_q   <= pulse_d;
			sum_q     <= sum_d;
			pending_q <= pending_d;
		end
	end

	// Result register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (accept) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data <= res_d;
		end
	end

	`UER_ASSERT_NOW(a_result_while_busy, res_valid && res_data.result_valid, res_data.busy_res, "result outside a busy round")
	`UER_ASSERT_NOW(a_trigger_onehot, res_valid, $onehot0(res_data.trigger_lines), "trigger lines not one-hot")
	`UER_ASSERT_NEXT(a_trig_to_wait, accept && phase_q == PH_TRIG, phase_q == PH_WAIT, "trigger tick not followed by wait")
	`UER_ASSERT_NOW(a_sensor_range, 1'b1, sensor_q <= LAST_SENSOR, "sensor index out of range")
	`UER_ASSERT_NOW(a_idle_clear, phase_q == PH_IDLE, sample_q == '0 && sensor_q == '0, "idle with sample or sensor left over")

endmodule

// ----- rtl/uer_classify.sv -----
// Alert classification of one sensor average against the thresholds.
module uer_classify
	import uer_pkg::*;
(
	input  logic [1:0]  sensor,
	input  logic [15:0] average,
	input  cfg_regs_t   cfg,
	output verdict_t    verdict
);

	// Side sensors: one threshold; front sensor: three nested limits
	always_comb begin
		verdict = '{alert_code: ALERT_NONE, beep_count: BEEP_NONE, voice_index: VOICE_NONE};
		if (sensor < FRONT_SENSOR) begin
			if (average < cfg.side_threshold) begin
				verdict.alert_code  = ALERT_SIDE;
				verdict.beep_count  = BEEP_ONE;
				verdict.voice_index = {1'b0, sensor};
			end
		end else begin
			priority if (average <= cfg.stop_limit) begin
				verdict.alert_code  = ALERT_STOP;
				verdict.beep_count  = BEEP_STOP;
				verdict.voice_index = VOICE_STOP;
			end else if (average <= cfg.danger_limit) begin
				verdict.alert_code  = ALERT_DANGER;
				verdict.beep_count  = BEEP_DANGER;
				verdict.voice_index = VOICE_DANGER;
			end else if (average <= cfg.front_limit) begin
				verdict.alert_code  = ALERT_FRONT;
				verdict.beep_count  = BEEP_ONE;
				verdict.voice_index = VOICE_FRONT;
			end else begin
				verdict.alert_code  = ALERT_NONE;
			end
		end
	end

endmodule

// ----- tb/sv/uer_range_checker.sv -----
// Checker for the echo ranger: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module uer_range_checker
	import uer_pkg::*;
#(
	parameter int SENSOR_COUNT = 3,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          mismatches,
	output int          outstanding
);

	// Predicted sequencer state and thresholds
	phase_t                 stage;
	logic [1:0]             sensor_at;
	int                     samples_done;
	logic [COUNT_WIDTH-1:0] echo_width;
	logic [63:0]            width_sum;
	logic                   round_owed;
	cfg_regs_t              limits;

	res_t due_reports[$];
	res_t want;
	int   err_cnt;

	// Advance the predicted sequencer by one tick and return its result
	function automatic res_t tick_report(req_t rq);
		res_t        o;
		logic        hit;
		logic [63:0] mean;
		logic [15:0] avg;
		o = '0;
		hit = rq.echo_levels[sensor_at];
		o.busy_res = (stage != PH_IDLE);
		if (stage == PH_IDLE) begin
			if (rq.start_request || round_owed) begin
				round_owed = 1'b0;
				sensor_at = '0;
				samples_done = 0;
				width_sum = '0;
				echo_width = '0;
				stage = PH_TRIG;
				o.busy_res = 1'b1;
			end
			return o;
		end
		// a request while busy is held for the next round
		if (rq.start_request)
			round_owed = 1'b1;
		case (stage)
			PH_TRIG: begin
				o.trigger_lines = 3'b001 << sensor_at;
				echo_width = '0;
				stage = PH_WAIT;
			end
			PH_WAIT: begin
				if (hit) begin
					echo_width = COUNT_WIDTH'(1);
					stage = PH_COUNT;
				end
			end
			default: begin
				if (hit) begin
					if (echo_width != {COUNT_WIDTH{1'b1}})
						echo_width++;
				end else begin
					width_sum += echo_width;
					samples_done++;
					if (samples_done < SAMPLE_COUNT) begin
						stage = PH_TRIG;
					end else begin
						mean = width_sum / SAMPLE_COUNT;
						avg = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
						o.result_valid = 1'b1;
						o.sensor_number = sensor_at;
						o.average_ticks = avg;
						// side sensors flag close objects, the front one grades distance
						if (sensor_at < FRONT_SENSOR) begin
							if (avg < limits.side_threshold) begin
								o.alert_code = ALERT_SIDE;
								o.beep_count = BEEP_ONE;
								o.voice_index = {1'b0, sensor_at};
							end
						end else if (avg <= limits.stop_limit) begin
							o.alert_code = ALERT_STOP;
							o.beep_count = BEEP_STOP;
							o.voice_index = VOICE_STOP;
						end else if (avg <= limits.danger_limit) begin
							o.alert_code = ALERT_DANGER;
							o.beep_count = BEEP_DANGER;
							o.voice_index = VOICE_DANGER;
						end else if (avg <= limits.front_limit) begin
							o.alert_code = ALERT_FRONT;
							o.beep_count = BEEP_ONE;
							o.voice_index = VOICE_FRONT;
						end
						samples_done = 0;
						width_sum = '0;
						if (sensor_at == SENSOR_COUNT - 1) begin
							sensor_at = '0;
							stage = PH_IDLE;
						end else begin
							sensor_at++;
							stage = PH_TRIG;
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	task automatic check_field(input string label, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			err_cnt++;
			$display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
		end
	endtask

	// Compare drained results, queue predictions, track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage = PH_IDLE;
			sensor_at = '0;
			samples_done = 0;
			echo_width = '0;
			width_sum = '0;
			round_owed = 1'b0;
			limits = {SIDE_THRESHOLD_RST, STOP_LIMIT_RST, DANGER_LIMIT_RST, FRONT_LIMIT_RST};
			due_reports.delete();
			err_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_reports.size() == 0) begin
					err_cnt++;
					$display("%0t: result with no request waiting, expected none, got %h",
						$time, res_data);
				end else begin
					want = due_reports.pop_front();
					check_field("trigger_lines", 16'(want.trigger_lines),
						16'(res_data.trigger_lines));
					check_field("busy_res", 16'(want.busy_res), 16'(res_data.busy_res));
					check_field("result_valid", 16'(want.result_valid),
						16'(res_data.result_valid));
					check_field("sensor_number", 16'(want.sensor_number),
						16'(res_data.sensor_number));
					check_field("average_ticks", want.average_ticks, res_data.average_ticks);
					check_field("alert_code", 16'(want.alert_code), 16'(res_data.alert_code));
					check_field("beep_count", 16'(want.beep_count), 16'(res_data.beep_count));
					check_field("voice_index", 16'(want.voice_index),
						16'(res_data.voice_index));
				end
			end
			if (req_valid && req_ready)
				due_reports.push_back(tick_report(req_data));
			if (cfg_we) begin
				case (cfg_index)
					REG_SIDE_THRESHOLD: limits.side_threshold = cfg_wdata;
					REG_STOP_LIMIT:     limits.stop_limit = cfg_wdata;
					REG_DANGER_LIMIT:   limits.danger_limit = cfg_wdata;
					default:            limits.front_limit = cfg_wdata;
				endcase
			end
			mismatches <= err_cnt;
			outstanding <= due_reports.size();
		end
	end

endmodule

// ----- tb/sv/tb_ultrasonic_echo_ranger_top.sv -----
// Testbench top for the echo ranger: tick stimulus, threshold settings and verdict.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_top;
	import uer_pkg::*;

	localparam int SENSORS     = 3;
	localparam int WIDTH       = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_TICKS  = 100;
	localparam int RANDOM_ROUNDS = 1;

	// Receiver flow modes
	localparam int FLOW_FREE   = 0;
	localparam int FLOW_CHOPPY = 1;
	localparam int FLOW_CHOKED = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req_data = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_SIDE_THRESHOLD;
	logic [15:0] cfg_wdata = '0;

	int   mismatches;
	int   outstanding;
	int   sent_items = 0;
	int   rounds_run = 0;
	int   settings_used = 1;
	int   burst_left = 0;
	int   quiet_cycles = 0;
	int   stall_left = 0;
	int   stall_mode = FLOW_FREE;
	logic extra_round = 1'b0;

	ultrasonic_echo_ranger_top #(
		.SENSOR_COUNT(SENSORS),
		.COUNT_WIDTH(WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	uer_range_checker #(
		.SENSOR_COUNT(SENSORS),
		.COUNT_WIDTH(WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the result side in stretches of free, choppy and choked flow
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(FLOW_FREE, FLOW_CHOKED);
			stall_left = $urandom_range(8, 120);
		end
		stall_left--;
		case (stall_mode)
			FLOW_FREE:   res_ready <= 1'b1;
			FLOW_CHOPPY: res_ready <= 1'($urandom_range(0, 1));
			default:     res_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Send one tick request, opening a new burst after a random gap when due
	task automatic send_tick(input logic start, input logic [2:0] echo);
		req_t item;
		int   gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item.start_request = start;
		item.echo_levels = echo;
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent_items++;
	endtask

	// Send a tick inside a round, now and then with a request to be latched
	task automatic busy_tick(input int start_permille, input logic [2:0] echo);
		logic st;
		st = ($urandom_range(0, 999) < start_permille);
		if (st)
			extra_round = 1'b1;
		send_tick(st, echo);
	endtask

	// Drive one complete round: start tick, then trigger, wait, count, end per sample
	task automatic run_round(input logic kick, input int cmax, input int wmax,
			input int start_permille, input int long_wait, input int long_count);
		int         base;
		int         width;
		int         hold;
		logic [2:0] mine;
		send_tick(kick, 3'($urandom_range(0, 7)));
		extra_round = 1'b0;
		for (int s = 0; s < SENSORS; s++) begin
			mine = 3'b001 << s;
			base = $urandom_range(1, cmax);
			for (int k = 0; k < SAMPLE_COUNT; k++) begin
				width = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cmax) : base;
				hold = $urandom_range(0, wmax);
				if (s == 0 && k == 0 && long_wait != 0)
					hold = long_wait;
				if (s == 0 && k == 0 && long_count != 0)
					width = long_count;
				busy_tick(start_permille, 3'($urandom_range(0, 7)));
				repeat (hold) busy_tick(start_permille, 3'($urandom_range(0, 7)) & ~mine);
				repeat (width) busy_tick(start_permille, 3'($urandom_range(0, 7)) | mine);
				busy_tick(start_permille, 3'($urandom_range(0, 7)) & ~mine);
			end
		end
		rounds_run++;
	endtask

	// Run a round and every round that latched requests call for
	task automatic run_rounds(input logic kick, input int cmax, input int wmax,
			input int start_permille, input int long_wait, input int long_count);
		run_round(kick, cmax, wmax, start_permille, long_wait, long_count);
		while (extra_round)
			run_round(1'($urandom_range(0, 1)), cmax, wmax, start_permille, 0, 0);
	endtask

	// Hold off until every result is back and the block has gone quiet
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic write_limits(input cfg_regs_t lim);
		write_reg(REG_SIDE_THRESHOLD, lim.side_threshold);
		write_reg(REG_STOP_LIMIT, lim.stop_limit);
		write_reg(REG_DANGER_LIMIT, lim.danger_limit);
		write_reg(REG_FRONT_LIMIT, lim.front_limit);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly small limits near the averages, sometimes an extreme
	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int random_from;
		int rounds_from;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// idle ticks without a request are ignored
		send_tick(1'b0, 3'b111);
		send_tick(1'b0, 3'b000);
		// reset thresholds, one sample with a long missing echo
		run_rounds(1'b1, 2, 1, 3, 20, 0);

		// top thresholds, one sample with a long echo
		wait_idle();
		write_limits({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		run_rounds(1'b1, 3, 0, 2, 0, 30);

		// zero thresholds: nothing alerts
		wait_idle();
		write_limits('0);
		run_rounds(1'b1, 6, 0, 0, 0, 0);

		// graded thresholds, then one set out of order
		wait_idle();
		write_limits({16'd3, 16'd1, 16'd2, 16'd4});
		run_rounds(1'b1, 6, 0, 1, 0, 0);
		wait_idle();
		write_limits({16'd2, 16'd2, 16'd3, 16'd5});
		run_rounds(1'b1, 6, 0, 1, 0, 0);
		wait_idle();
		write_limits({16'd5, 16'd4, 16'd2, 16'd1});
		run_rounds(1'b1, 6, 0, 1, 0, 0);

		// random rounds with idle noise and fresh thresholds now and then
		random_from = sent_items;
		rounds_from = rounds_run;
		while ((sent_items - random_from) < RANDOM_TICKS
				|| (rounds_run - rounds_from) < RANDOM_ROUNDS) begin
			if ($urandom_range(0, 1) == 0) begin
				wait_idle();
				write_limits({pick_limit(), pick_limit(), pick_limit(), pick_limit()});
			end
			repeat ($urandom_range(0, 3)) send_tick(1'b0, 3'($urandom_range(0, 7)));
			run_rounds(1'b1, $urandom_range(1, 8), $urandom_range(0, 3),
				$urandom_range(0, 6), 0, 0);
		end

		// unstructured ticks to finish
		repeat (30) send_tick($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)));

		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Covered %0d tick requests in %0d ranging rounds under %0d threshold settings",
			sent_items, rounds_run, settings_used);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
